// ===== rtl/tmpd_pkg.sv =====
// tmpd_pkg: shared constants, codes and types for the timeout motor pwm driver
// no dependencies; used by timeout_motor_pwm_driver

package tmpd_pkg;

   localparam int unsigned TIME_WIDTH    = 32;
   localparam int unsigned SPEED_WIDTH   = 15;
   localparam int unsigned TIMER_WIDTH   = 16;
   localparam int unsigned PRODUCT_WIDTH = TIMER_WIDTH + SPEED_WIDTH;

   localparam logic [SPEED_WIDTH-1:0] FULL_SPEED = 15'd25600;

   // 25600 = 25 * 2**10; divide by 25 through a rounded-up reciprocal
   localparam int unsigned POW2_SHIFT    = 10;
   localparam int unsigned QUOT_IN_WIDTH = PRODUCT_WIDTH - POW2_SHIFT;
   localparam int unsigned RECIP_WIDTH   = 22;
   localparam int unsigned RECIP_SHIFT   = 26;
   localparam logic [RECIP_WIDTH-1:0] RECIP_25 = 22'd2684355;
   localparam int unsigned RECIP_PROD_WIDTH = QUOT_IN_WIDTH + RECIP_WIDTH;

   localparam logic [1:0] CMD_TICK      = 2'd0;
   localparam logic [1:0] CMD_SET_TIME  = 2'd1;
   localparam logic [1:0] CMD_SET_DIR   = 2'd2;
   localparam logic [1:0] CMD_SET_SPEED = 2'd3;

   localparam logic [1:0] MODE_DIRECT   = 2'd0;
   localparam logic [1:0] MODE_SPEED_DIR = 2'd1;
   localparam logic [1:0] MODE_LEFT_RIGHT = 2'd2;

   localparam logic [1:0] REG_TIMER_MAX   = 2'd0;
   localparam logic [1:0] REG_INVERTED    = 2'd1;
   localparam logic [1:0] REG_DRIVE_MODE  = 2'd2;
   localparam logic [1:0] REG_TICK_LENGTH = 2'd3;

   typedef struct packed {
      logic                     pin_a;
      logic                     pin_b;
      logic [PRODUCT_WIDTH-1:0] product;
      logic                     running;
   } stage_type;

   typedef struct packed {
      logic                   pin_a;
      logic                   pin_b;
      logic [TIMER_WIDTH-1:0] compare_value;
      logic                   running;
   } result_type;

endpackage

// ===== rtl/timeout_motor_pwm_driver.sv =====
// timeout_motor_pwm_driver: motor drive with run timeout, pin levels and pwm compare value
// depends on tmpd_pkg
//
//   channel  | role            | ports
//   req_     | event beats in  | req_tvalid, req_tready, req_tdata, req_tuser
//   rsp_     | result beats out| rsp_tvalid, rsp_tready, rsp_tdata
//   csr_     | register access | csr_psel, csr_penable, csr_pwrite, csr_paddr, ...
//
// one beat per cycle sustained while rsp_tready holds; a beat passes the stage and result registers to rsp_tvalid
// state is updated and timer_max * duty formed in the accept cycle, the
// reciprocal divide by 25600 in the second stage
// reset is synchronous and clears state to its idle values, no clearing pass
// a stalled output holds both stages; req_tready drops only when both are full

module timeout_motor_pwm_driver (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // remaining_time [31:0], drive_direction [32], speed_request [48:33], zero fill
   input  logic [55:0] req_tdata,
   // command [1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // pin_a [0], pin_b [1], compare_value [17:2], running [18], zero fill
   output logic [23:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [tmpd_pkg::TIMER_WIDTH-1:0] timer_max_ff;
   logic                             inverted_ff;
   logic [1:0]                       drive_mode_ff;
   logic [tmpd_pkg::TIMER_WIDTH-1:0] tick_length_ff;

   logic [tmpd_pkg::TIME_WIDTH-1:0]  time_left_ff, time_left_in;
   logic [tmpd_pkg::SPEED_WIDTH-1:0] requested_speed_ff, requested_speed_in;
   logic [tmpd_pkg::SPEED_WIDTH-1:0] applied_speed_ff, applied_speed_in;
   logic                             direction_bit_ff, direction_bit_in;

   tmpd_pkg::stage_type  stage_ff, stage_in;
   logic                 stage_valid_ff;
   tmpd_pkg::result_type result_ff, result_in;
   logic                 result_valid_ff;

   logic                 result_ready;
   logic                 stage_ready;
   logic                 req_beat;
   logic                 csr_write;

   logic [tmpd_pkg::TIME_WIDTH-1:0]  req_time;
   logic                             req_dir;
   logic signed [15:0]               req_speed;
   logic [tmpd_pkg::SPEED_WIDTH-1:0] clamped_speed;
   logic [tmpd_pkg::SPEED_WIDTH-1:0] duty;
   logic                             pin_a_in, pin_b_in;

   logic [tmpd_pkg::QUOT_IN_WIDTH-1:0]    quot_in;
   logic [tmpd_pkg::RECIP_PROD_WIDTH-1:0] recip_prod;

   assign req_time  = req_tdata[31:0];
   assign req_dir   = req_tdata[32];
   assign req_speed = req_tdata[48:33];

   assign result_ready = !result_valid_ff || rsp_tready;
   assign stage_ready  = !stage_valid_ff || result_ready;
   assign req_tready   = stage_ready;
   assign req_beat     = req_tvalid && req_tready;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_max_ff   <= 16'd255;
         inverted_ff    <= 1'b0;
         drive_mode_ff  <= tmpd_pkg::MODE_DIRECT;
         tick_length_ff <= 16'd1;
      end else if (csr_write) begin
         unique case (csr_paddr[3:2])
            tmpd_pkg::REG_TIMER_MAX:   timer_max_ff   <= csr_pwdata[15:0];
            tmpd_pkg::REG_INVERTED:    inverted_ff    <= csr_pwdata[0];
            tmpd_pkg::REG_DRIVE_MODE:  drive_mode_ff  <= csr_pwdata[1:0];
            tmpd_pkg::REG_TICK_LENGTH: tick_length_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         tmpd_pkg::REG_TIMER_MAX:   csr_prdata = {16'd0, timer_max_ff};
         tmpd_pkg::REG_INVERTED:    csr_prdata = {31'd0, inverted_ff};
         tmpd_pkg::REG_DRIVE_MODE:  csr_prdata = {30'd0, drive_mode_ff};
         tmpd_pkg::REG_TICK_LENGTH: csr_prdata = {16'd0, tick_length_ff};
         default:                   csr_prdata = 32'd0;
      endcase
   end

   // event decode and state update
   always_comb begin
      if (req_speed < 0) begin
         clamped_speed = '0;
      end else if (req_speed > 16'sd25600) begin
         clamped_speed = tmpd_pkg::FULL_SPEED;
      end else begin
         clamped_speed = req_speed[14:0];
      end
   end

   always_comb begin
      time_left_in       = time_left_ff;
      requested_speed_in = requested_speed_ff;
      applied_speed_in   = applied_speed_ff;
      direction_bit_in   = direction_bit_ff;
      case (req_tuser)
         tmpd_pkg::CMD_TICK: begin
            if (time_left_ff != '0) begin
               if (time_left_ff <= {16'd0, tick_length_ff}) begin
                  time_left_in     = '0;
                  applied_speed_in = '0;
               end else begin
                  time_left_in = time_left_ff - {16'd0, tick_length_ff};
               end
            end
         end
         tmpd_pkg::CMD_SET_TIME: begin
            time_left_in = req_time;
            if (req_time != '0) begin
               applied_speed_in = requested_speed_ff;
            end
         end
         tmpd_pkg::CMD_SET_DIR: begin
            direction_bit_in = req_dir;
         end
         default: begin
            requested_speed_in = clamped_speed;
            if (time_left_ff != '0) begin
               applied_speed_in = clamped_speed;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_left_ff       <= '0;
         requested_speed_ff <= '0;
         applied_speed_ff   <= '0;
         direction_bit_ff   <= 1'b1;
      end else if (req_beat) begin
         time_left_ff       <= time_left_in;
         requested_speed_ff <= requested_speed_in;
         applied_speed_ff   <= applied_speed_in;
         direction_bit_ff   <= direction_bit_in;
      end
   end

   // pins and duty from the updated state
   always_comb begin
      logic [tmpd_pkg::SPEED_WIDTH-1:0] raw_duty;
      raw_duty = applied_speed_in;
      pin_a_in = 1'b0;
      pin_b_in = 1'b0;
      case (drive_mode_ff) inside
         tmpd_pkg::MODE_DIRECT, tmpd_pkg::MODE_SPEED_DIR: begin
            pin_a_in = (applied_speed_in == '0) ? inverted_ff : direction_bit_in;
            if (drive_mode_ff == tmpd_pkg::MODE_DIRECT && direction_bit_in) begin
               raw_duty = tmpd_pkg::FULL_SPEED - applied_speed_in;
            end
         end
         tmpd_pkg::MODE_LEFT_RIGHT: begin
            if (applied_speed_in != '0) begin
               pin_a_in = !direction_bit_in;
               pin_b_in = direction_bit_in;
            end
         end
         default: ;
      endcase
      duty = inverted_ff ? (tmpd_pkg::FULL_SPEED - raw_duty) : raw_duty;
   end

   always_comb begin
      stage_in.pin_a   = pin_a_in;
      stage_in.pin_b   = pin_b_in;
      stage_in.product = tmpd_pkg::PRODUCT_WIDTH'(timer_max_ff)
                       * tmpd_pkg::PRODUCT_WIDTH'(duty);
      stage_in.running = (time_left_in != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (stage_ready) begin
         stage_valid_ff <= req_beat;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         stage_ff <= stage_in;
      end
   end

   // divide by 25600: shift out 2**10, then multiply by the reciprocal of 25
   assign quot_in    = stage_ff.product[tmpd_pkg::PRODUCT_WIDTH-1:tmpd_pkg::POW2_SHIFT];
   assign recip_prod = tmpd_pkg::RECIP_PROD_WIDTH'(quot_in)
                     * tmpd_pkg::RECIP_PROD_WIDTH'(tmpd_pkg::RECIP_25);

   always_comb begin
      result_in.pin_a         = stage_ff.pin_a;
      result_in.pin_b         = stage_ff.pin_b;
      result_in.compare_value =
         recip_prod[tmpd_pkg::RECIP_SHIFT+tmpd_pkg::TIMER_WIDTH-1:tmpd_pkg::RECIP_SHIFT];
      result_in.running       = stage_ff.running;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         result_valid_ff <= 1'b0;
      end else if (result_ready) begin
         result_valid_ff <= stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (result_ready && stage_valid_ff) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = result_valid_ff;
   assign rsp_tdata  = {5'd0, result_ff.running, result_ff.compare_value,
                        result_ff.pin_b, result_ff.pin_a};

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      applied_speed_ff <= tmpd_pkg::FULL_SPEED
      && requested_speed_ff <= tmpd_pkg::FULL_SPEED)
      else $error("speed state above full speed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[1]))
      else $error("both direction pins driven high");

   assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && !result_ready |=> stage_valid_ff && $stable(stage_ff))
      else $error("stalled middle stage changed");

   assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && result_valid_ff && !rsp_tready |-> !req_tready)
      else $error("input taken with pipeline full");
`endif

endmodule

// ===== tb/timeout_motor_pwm_driver_tb.sv =====
// timeout_motor_pwm_driver_tb: self-checking bench for the timeout motor pwm driver
// predicts pin levels, compare value and running flag per event beat, random stalls both sides
// depends on tmpd_pkg and timeout_motor_pwm_driver

module timeout_motor_pwm_driver_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int PHASE_COUNT = 9;
   localparam int PHASE_BEATS = 92;

   class pwm_drive_predictor;
      logic [15:0] timer_max;
      logic        inverted;
      logic [1:0]  drive_mode;
      logic [15:0] tick_length;
      logic [31:0] time_left;
      logic [14:0] requested_speed;
      logic [14:0] applied_speed;
      logic        direction_bit;
      tmpd_pkg::result_type expected_results[$];
      int          mismatches;

      function new();
         timer_max       = 16'd255;
         inverted        = 1'b0;
         drive_mode      = tmpd_pkg::MODE_DIRECT;
         tick_length     = 16'd1;
         time_left       = '0;
         requested_speed = '0;
         applied_speed   = '0;
         direction_bit   = 1'b1;
         mismatches      = 0;
      endfunction

      function void write_reg(logic [1:0] index, logic [31:0] value);
         case (index)
            tmpd_pkg::REG_TIMER_MAX:   timer_max   = value[15:0];
            tmpd_pkg::REG_INVERTED:    inverted    = value[0];
            tmpd_pkg::REG_DRIVE_MODE:  drive_mode  = value[1:0];
            tmpd_pkg::REG_TICK_LENGTH: tick_length = value[15:0];
         endcase
      endfunction

      function void note_event(logic [1:0] command, logic [31:0] run_time, logic dir,
                               logic [15:0] speed);
         logic [14:0] duty;
         logic [31:0] product;
         tmpd_pkg::result_type want;
         case (command)
            tmpd_pkg::CMD_TICK: begin
               if (time_left != 0) begin
                  if (time_left <= {16'd0, tick_length}) begin
                     time_left     = '0;
                     applied_speed = '0;
                  end else begin
                     time_left = time_left - {16'd0, tick_length};
                  end
               end
            end
            tmpd_pkg::CMD_SET_TIME: begin
               time_left = run_time;
               if (time_left != 0) applied_speed = requested_speed;
            end
            tmpd_pkg::CMD_SET_DIR: direction_bit = dir;
            tmpd_pkg::CMD_SET_SPEED: begin
               if (speed[15]) requested_speed = '0;
               else if (speed[14:0] > tmpd_pkg::FULL_SPEED) begin
                  requested_speed = tmpd_pkg::FULL_SPEED;
               end
               else requested_speed = speed[14:0];
               if (time_left != 0) applied_speed = requested_speed;
            end
         endcase
         want       = '0;
         duty       = applied_speed;
         if (drive_mode == tmpd_pkg::MODE_DIRECT || drive_mode == tmpd_pkg::MODE_SPEED_DIR) begin
            want.pin_a = (applied_speed == 0) ? inverted : direction_bit;
            if (drive_mode == tmpd_pkg::MODE_DIRECT && direction_bit) begin
               duty = tmpd_pkg::FULL_SPEED - duty;
            end
         end else if (drive_mode == tmpd_pkg::MODE_LEFT_RIGHT && applied_speed != 0) begin
            if (direction_bit) want.pin_b = 1'b1;
            else want.pin_a = 1'b1;
         end
         if (inverted) duty = tmpd_pkg::FULL_SPEED - duty;
         product            = {16'd0, timer_max} * {17'd0, duty};
         want.compare_value = 16'(product / 32'(tmpd_pkg::FULL_SPEED));
         want.running       = (time_left != 0);
         expected_results.push_back(want);
      endfunction

      function void report(string field, int want, int got);
         if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(tmpd_pkg::result_type got);
         tmpd_pkg::result_type want;
         if (expected_results.size() == 0) begin
            $display("%0t: result beat with nothing expected, actual %p", $time, got);
            mismatches++;
            return;
         end
         want = expected_results.pop_front();
         report("pin_a", want.pin_a, got.pin_a);
         report("pin_b", want.pin_b, got.pin_b);
         report("compare_value", want.compare_value, got.compare_value);
         report("running", want.running, got.running);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic [1:0]  req_tuser = tmpd_pkg::CMD_TICK;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [23:0] rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   pwm_drive_predictor pwm_expect = new();
   bit gaps_on = 1'b1;
   bit stalls_on = 1'b1;
   int stall_left = 0;

   timeout_motor_pwm_driver u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 10);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      tmpd_pkg::result_type got;
      if (!reset) begin
         if (req_tvalid && req_tready)
            pwm_expect.note_event(req_tuser, req_tdata[31:0], req_tdata[32], req_tdata[48:33]);
         if (rsp_tvalid && rsp_tready) begin
            got.pin_a         = rsp_tdata[0];
            got.pin_b         = rsp_tdata[1];
            got.compare_value = rsp_tdata[17:2];
            got.running       = rsp_tdata[18];
            pwm_expect.check_result(got);
         end
      end
   end

   task automatic send_event(logic [1:0] command, logic [31:0] run_time, logic dir,
                             logic [15:0] speed);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= command;
      req_tdata  <= {7'd0, speed, dir, run_time};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pwm_expect.expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] index, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      pwm_expect.write_reg(index, value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic program_regs(logic [31:0] top, logic [31:0] inv, logic [31:0] mode,
                               logic [31:0] tick);
      drain_results();
      csr_write(tmpd_pkg::REG_TIMER_MAX, top);
      csr_write(tmpd_pkg::REG_INVERTED, inv);
      csr_write(tmpd_pkg::REG_DRIVE_MODE, mode);
      csr_write(tmpd_pkg::REG_TICK_LENGTH, tick);
   endtask

   function automatic logic [31:0] pick_run_time();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return 32'hFFFF_FFFF;
         2, 3:    return $urandom();
         4:       return $urandom_range(1, 3000);
         default: return $urandom_range(1, 24);
      endcase
   endfunction

   function automatic logic [15:0] pick_speed();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return 16'h8000 | 16'($urandom());
         2:       return 16'($urandom());
         3:       return 16'($urandom_range(25590, 25620));
         default: return 16'($urandom_range(0, 25600));
      endcase
   endfunction

   function automatic logic [1:0] pick_command();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return tmpd_pkg::CMD_TICK;
      if (roll < 60) return tmpd_pkg::CMD_SET_TIME;
      if (roll < 75) return tmpd_pkg::CMD_SET_DIR;
      return tmpd_pkg::CMD_SET_SPEED;
   endfunction

   function automatic logic [31:0] pick_tick_length();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return 32'd65535;
         2:       return $urandom();
         default: return $urandom_range(1, 8);
      endcase
   endfunction

   function automatic logic [31:0] pick_timer_max();
      if ($urandom_range(0, 3) == 0) return $urandom();
      return 32'd255 << $urandom_range(0, 8);
   endfunction

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: direct mode, tick length one
      send_event(tmpd_pkg::CMD_TICK, 32'd7, 1'b0, 16'd100);
      send_event(tmpd_pkg::CMD_SET_SPEED, 32'd0, 1'b1, 16'd12800);
      send_event(tmpd_pkg::CMD_SET_TIME, 32'd0, 1'b0, 16'd0);
      send_event(tmpd_pkg::CMD_SET_TIME, 32'd3, 1'b1, 16'h7FFF);
      send_event(tmpd_pkg::CMD_SET_DIR, 32'hFFFF_FFFF, 1'b0, 16'hFFFF);
      send_event(tmpd_pkg::CMD_TICK, 32'd0, 1'b1, 16'd0);
      send_event(tmpd_pkg::CMD_SET_SPEED, 32'd0, 1'b0, 16'h8000);
      send_event(tmpd_pkg::CMD_SET_SPEED, 32'd0, 1'b0, 16'h7FFF);
      send_event(tmpd_pkg::CMD_SET_SPEED, 32'd0, 1'b0, 16'd25601);
      send_event(tmpd_pkg::CMD_SET_SPEED, 32'd0, 1'b0, 16'd0);
      send_event(tmpd_pkg::CMD_SET_SPEED, 32'd0, 1'b0, 16'd25600);
      send_event(tmpd_pkg::CMD_SET_DIR, 32'd0, 1'b1, 16'd0);
      send_event(tmpd_pkg::CMD_SET_TIME, 32'd0, 1'b0, 16'd0);
      send_event(tmpd_pkg::CMD_TICK, 32'd0, 1'b0, 16'd0);
      send_event(tmpd_pkg::CMD_SET_TIME, 32'hFFFF_FFFF, 1'b0, 16'd0);
      send_event(tmpd_pkg::CMD_TICK, 32'd0, 1'b0, 16'd0);
      send_event(tmpd_pkg::CMD_SET_TIME, 32'd2, 1'b0, 16'd0);
      send_event(tmpd_pkg::CMD_TICK, 32'd0, 1'b0, 16'd0);
      send_event(tmpd_pkg::CMD_TICK, 32'd0, 1'b0, 16'd0);

      // zero tick length holds the run time
      program_regs(32'd65535, 32'd1, 32'(tmpd_pkg::MODE_DIRECT), 32'd0);
      send_event(tmpd_pkg::CMD_SET_TIME, 32'd5, 1'b0, 16'd0);
      send_event(tmpd_pkg::CMD_SET_SPEED, 32'd0, 1'b0, 16'd12800);
      send_event(tmpd_pkg::CMD_TICK, 32'd0, 1'b0, 16'd0);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: program_regs(32'd65535, 32'd1, 32'(MODE_UNUSED), 32'd65535);
            1: program_regs(32'd0, 32'd0, 32'(tmpd_pkg::MODE_LEFT_RIGHT), 32'd1);
            2: program_regs(32'hFFFF_FFFF, 32'd0, 32'(tmpd_pkg::MODE_SPEED_DIR), 32'd0);
            default: program_regs(pick_timer_max(), $urandom(), $urandom_range(0, 3),
                                  pick_tick_length());
         endcase
         gaps_on   = (phase != PHASE_COUNT - 1) && ($urandom_range(0, 3) != 0);
         stalls_on = (phase != PHASE_COUNT - 1) && ($urandom_range(0, 3) != 0);
         for (int n = 0; n < PHASE_BEATS; n++)
            send_event(pick_command(), pick_run_time(), 1'($urandom_range(0, 1)), pick_speed());
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (pwm_expect.mismatches == 0 && pwm_expect.expected_results.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
